>>> hdl/fat_chain_block_allocator_core_defines.svh
// assertion macros for the block allocator
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define FCBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// consequent must hold in the same cycle as the antecedent
`define FCBA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

`endif

>>> hdl/fcba_pkg.sv
package fcba_pkg;

   // store geometry, block size is a power of two of at least two bytes
   localparam int NUM_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 4096;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   localparam int ADDR_W = $clog2(NUM_BLOCKS);
   localparam int LINK_W = ADDR_W + 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int SIZE_W = 32;
   localparam int NEED_W = SIZE_W - BLOCK_SHIFT + 1;

   // link value that ends a chain
   localparam logic [LINK_W-1:0] CHAIN_END = '1;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_FORMAT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_HEAD_UNUSED = 2'd2
   } status_type;

   typedef struct packed {
      logic load_req;
      logic start;
      logic clr_step;
      logic scan_step;
      logic tail;
      logic walk_rd;
      logic walk_chk;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   need_zero;
      logic   need_over;
      logic   clr_last;
      logic   left_zero;
      logic   scan_done;
      logic   walk_ok;
      logic   walk_used;
      logic   rsp_busy;
   } stat_type;

endpackage

>>> hdl/fcba_ram.sv
module fcba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fcba_dp.sv
module fcba_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  fcba_pkg::cmd_type         cmd,
   output fcba_pkg::stat_type        stat,
   input  logic [1:0]                req_op,
   input  logic [fcba_pkg::SIZE_W-1:0] req_size,
   input  logic [fcba_pkg::ADDR_W-1:0] req_head,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output fcba_pkg::status_type      rsp_status,
   output logic [fcba_pkg::ADDR_W-1:0] rsp_first,
   output logic [fcba_pkg::CNT_W-1:0]  rsp_count,
   output logic [fcba_pkg::CNT_W-1:0]  rsp_free
);

   localparam int AW = fcba_pkg::ADDR_W;
   localparam int LW = fcba_pkg::LINK_W;
   localparam int CW = fcba_pkg::CNT_W;
   localparam int NW = fcba_pkg::NEED_W;
   localparam int BS = fcba_pkg::BLOCK_SHIFT;
   localparam int SW = fcba_pkg::SIZE_W;

   // request registers
   fcba_pkg::op_type     op_ff;
   logic [NW-1:0]        need_ff, need_in;
   logic [AW-1:0]        head_ff;

   // control state
   logic [CW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [AW-1:0]        tag_ff, tag_in;
   logic [CW-1:0]        left_ff, left_in;
   logic [AW-1:0]        prev_ff, prev_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic [AW-1:0]        first_ff, first_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        free_ff, free_in;
   logic [LW-1:0]        cur_ff, cur_in;
   fcba_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // response payload
   fcba_pkg::status_type rsp_status_ff;
   logic [AW-1:0]        rsp_first_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic [CW-1:0]        rsp_free_ff;

   // memory ports
   logic          used_we, used_wd, used_re, used_rd;
   logic [AW-1:0] used_wa, used_ra;
   logic          chain_we;
   logic [AW-1:0] chain_wa;
   logic [LW-1:0] chain_wd, chain_rd;

   logic scan_re, found;

   // blocks needed, rounded up
   assign need_in = {1'b0, req_size[SW-1:BS]} + NW'(|req_size[BS-1:0]);

   assign scan_re = cmd.scan_step && (scan_addr_ff < CW'(fcba_pkg::NUM_BLOCKS));
   assign found   = cmd.scan_step && rd_valid_ff && !used_rd && (left_ff != '0);

   always_comb begin
      used_we = 1'b0;
      used_wa = scan_addr_ff[AW-1:0];
      used_wd = 1'b0;
      if (cmd.clr_step) begin
         used_we = 1'b1;
      end else if (found) begin
         used_we = 1'b1;
         used_wa = tag_ff;
         used_wd = 1'b1;
      end else if (cmd.walk_chk && used_rd) begin
         used_we = 1'b1;
         used_wa = cur_ff[AW-1:0];
      end
   end

   assign used_re = scan_re || cmd.walk_rd;
   assign used_ra = cmd.scan_step ? scan_addr_ff[AW-1:0] : cur_ff[AW-1:0];

   assign chain_we = prev_valid_ff && (found || cmd.tail);
   assign chain_wa = prev_ff;
   assign chain_wd = cmd.tail ? fcba_pkg::CHAIN_END : LW'(tag_ff);

   fcba_ram #(
      .WIDTH (1),
      .DEPTH (fcba_pkg::NUM_BLOCKS)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_wa),
      .wr_data (used_wd),
      .rd_en   (used_re),
      .rd_addr (used_ra),
      .rd_data (used_rd)
   );

   fcba_ram #(
      .WIDTH (LW),
      .DEPTH (fcba_pkg::NUM_BLOCKS)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_we),
      .wr_addr (chain_wa),
      .wr_data (chain_wd),
      .rd_en   (cmd.walk_rd),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (chain_rd)
   );

   always_comb begin
      scan_addr_in  = scan_addr_ff;
      rd_valid_in   = rd_valid_ff;
      tag_in        = tag_ff;
      left_in       = left_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.start) begin
         scan_addr_in  = '0;
         rd_valid_in   = 1'b0;
         left_in       = CW'(need_ff);
         prev_valid_in = 1'b0;
         first_in      = '0;
         count_in      = '0;
         cur_in        = LW'(head_ff);
         status_in     = fcba_pkg::ST_OK;
         if (op_ff == fcba_pkg::OP_ALLOC && stat.need_over) begin
            status_in = fcba_pkg::ST_NO_SPACE;
         end
      end

      if (cmd.clr_step) begin
         scan_addr_in = scan_addr_ff + CW'(1);
         if (stat.clr_last) begin
            scan_addr_in = '0;
            free_in      = CW'(fcba_pkg::NUM_BLOCKS);
         end
      end

      if (cmd.scan_step) begin
         rd_valid_in  = scan_re;
         tag_in       = scan_addr_ff[AW-1:0];
         scan_addr_in = scan_addr_ff + CW'(scan_re);
         if (found) begin
            if (!prev_valid_ff) begin
               first_in = tag_ff;
            end
            prev_in       = tag_ff;
            prev_valid_in = 1'b1;
            left_in       = left_ff - CW'(1);
            count_in      = count_ff + CW'(1);
         end
      end

      if (cmd.tail) begin
         free_in = free_ff - count_ff;
      end

      if (cmd.walk_chk) begin
         if (used_rd) begin
            count_in = count_ff + CW'(1);
            cur_in   = chain_rd;
            if (free_ff < CW'(fcba_pkg::NUM_BLOCKS)) begin
               free_in = free_ff + CW'(1);
            end
         end else if (count_ff == '0) begin
            status_in = fcba_pkg::ST_HEAD_UNUSED;
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         left_ff       <= '0;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
         free_ff       <= CW'(fcba_pkg::NUM_BLOCKS);
         status_ff     <= fcba_pkg::ST_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_addr_ff  <= scan_addr_in;
         rd_valid_ff   <= rd_valid_in;
         left_ff       <= left_in;
         prev_valid_ff <= prev_valid_in;
         count_ff      <= count_in;
         free_ff       <= free_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      prev_ff  <= prev_in;
      first_ff <= first_in;
      cur_ff   <= cur_in;
      if (cmd.load_req) begin
         op_ff   <= fcba_pkg::op_type'(req_op);
         need_ff <= need_in;
         head_ff <= req_head;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_first_ff  <= first_ff;
         rsp_count_ff  <= count_ff;
         rsp_free_ff   <= free_ff;
      end
   end

   assign stat.op        = op_ff;
   assign stat.need_zero = (need_ff == '0);
   assign stat.need_over = ((SW + 1)'(need_ff) > (SW + 1)'(free_ff));
   assign stat.clr_last  = (scan_addr_ff[AW-1:0] == AW'(fcba_pkg::NUM_BLOCKS - 1));
   assign stat.left_zero = (left_ff == '0);
   assign stat.scan_done = (scan_addr_ff == CW'(fcba_pkg::NUM_BLOCKS)) && !rd_valid_ff;
   assign stat.walk_ok   = (cur_ff < LW'(fcba_pkg::NUM_BLOCKS))
                           && (count_ff < CW'(fcba_pkg::NUM_BLOCKS));
   assign stat.walk_used = used_rd;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_first  = rsp_first_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_free   = rsp_free_ff;

endmodule

>>> hdl/fcba_ctrl.sv
module fcba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fcba_pkg::stat_type stat,
   output fcba_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_SCAN,
      S_TAIL,
      S_WALK_RD,
      S_WALK_CHK,
      S_FORMAT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.load_req = 1'b1;
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            case (stat.op)
               fcba_pkg::OP_ALLOC: begin
                  state_in = (stat.need_zero || stat.need_over) ? S_DONE : S_SCAN;
               end
               fcba_pkg::OP_FREE:   state_in = S_WALK_RD;
               fcba_pkg::OP_FORMAT: state_in = S_FORMAT;
               default:             state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.left_zero || stat.scan_done) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            state_in = S_DONE;
         end
         S_WALK_RD: begin
            if (stat.walk_ok) begin
               cmd.walk_rd = 1'b1;
               state_in    = S_WALK_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WALK_CHK: begin
            cmd.walk_chk = 1'b1;
            state_in     = stat.walk_used ? S_WALK_RD : S_DONE;
         end
         S_FORMAT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> hdl/fat_chain_block_allocator_core.sv
// time from the accepting edge to rsp_tvalid depends on the operation:
// allocate grows with the blocks scanned through the last one taken
// free grows with the blocks freed, with an extra read when the walk stops on a free block; format sweeps every block
// zero size, no space or an unused operation code go straight to the result
// one operation at a time; a result still waiting on rsp_tready holds the next operation in its done state
// reset is synchronous, then a sweep clears the used map before req_tready rises
`include "fat_chain_block_allocator_core_defines.svh"

module fat_chain_block_allocator_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // size_bytes[31:0], head_block[41:32], zero pad
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // first_block[9:0], block_count[20:10], free_blocks[31:21]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   // controller and datapath talk only through these two groups
   fcba_pkg::cmd_type  cmd;
   fcba_pkg::stat_type stat;

   fcba_pkg::status_type               rsp_status;
   logic [fcba_pkg::ADDR_W-1:0]        rsp_first;
   logic [fcba_pkg::CNT_W-1:0]         rsp_count;
   logic [fcba_pkg::CNT_W-1:0]         rsp_free;

   // sequencer: reset sweep, first-fit scan, chain walk, format sweep
   fcba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // holds the used map and chain table rams, counters and the result register
   fcba_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_size   (req_tdata[31:0]),
      .req_head   (req_tdata[41:32]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_first  (rsp_first),
      .rsp_count  (rsp_count),
      .rsp_free   (rsp_free)
   );

   // result beat packing
   assign rsp_tdata = {rsp_free, rsp_count, rsp_first};
   assign rsp_tuser = rsp_status;

   // once a beat is taken the block is busy in the cycle after
   `FCBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // the free counter never passes the store size
   `FCBA_ASSERT_SAME(a_free_in_range, clock, reset, rsp_tvalid,
                     rsp_free <= fcba_pkg::CNT_W'(fcba_pkg::NUM_BLOCKS))

   // a failed operation moves no blocks
   `FCBA_ASSERT_SAME(a_fail_no_blocks, clock, reset,
                     rsp_tvalid && (rsp_status != fcba_pkg::ST_OK),
                     (rsp_count == '0) && (rsp_first == '0))

endmodule
